/* rtl/core/tbr_pkg.sv */
// Shared constants, stage map and types for the thermistor B-parameter pipeline.
// Depends on nothing; imported by the top level, its checker and the bench.
package tbr_pkg;

    localparam int TEMP_W = 16;
    localparam int BETA_W = 16;
    localparam int NOM_W  = 24;
    localparam int RES_W  = 32;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam int FRAC_BITS = 32;

    // Register offsets, selected by paddr[2].
    localparam logic CFG_BETA    = 1'b0;
    localparam logic CFG_NOMINAL = 1'b1;

    localparam logic [BETA_W-1:0] BETA_RESET    = 16'd3455;
    localparam logic [NOM_W-1:0]  NOMINAL_RESET = 24'd10000;

    // Absolute temperature in hundredths of a kelvin.
    localparam logic [17:0] KELVIN_OFFSET = 18'd27315;
    localparam logic [15:0] T0_HUNDREDTHS = 16'd29815;

    // Reciprocal: (100 << FRAC_BITS) / T, restoring divider.
    localparam int NUM_W = 40;
    localparam logic [NUM_W-1:0] RECIP_NUM = 40'd100 << FRAC_BITS;
    localparam logic [NUM_W-1:0] RECIP_T0  = RECIP_NUM / NUM_W'(T0_HUNDREDTHS);
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = NUM_W / DIV_STEPS;

    // Exponent limit is 32 << FRAC_BITS = 2^37.
    localparam int AXP_W      = NUM_W + BETA_W;
    localparam int LIMIT_LOG2 = 37;

    // Range reduction constants.
    localparam logic [63:0] LN2_Q62 = 64'h2C5C85FDF473DE6B;
    localparam logic [31:0] LN2_F   = 32'(LN2_Q62 >> (62 - FRAC_BITS));
    localparam int RED_W = 39;
    localparam logic [RED_W-1:0] RANGE_OFFSET = RED_W'(64'd47 * 64'(LN2_F));
    localparam int K_W = 7;
    localparam int PRE_SHIFT = 14;
    localparam logic [K_W-1:0] SHIFT_BIAS = 7'd93;

    // Taylor series: each term divided by n through a reciprocal multiply.
    localparam int TAYLOR_TERMS = 18;
    localparam int RECIP_SHIFT  = 37;
    localparam int MULT_W       = RECIP_SHIFT + 1;
    localparam int TERM_W       = 33;
    localparam int SUM_W        = 34;
    localparam int PROD_W       = NOM_W + SUM_W;
    localparam logic [TERM_W-1:0] ONE_Q = 33'd1 << FRAC_BITS;

    // Pipeline stage map.
    localparam int ST_IN       = 0;
    localparam int ST_DIV0     = 1;
    localparam int ST_DIV_LAST = ST_DIV0 + DIV_STAGES - 1;
    localparam int ST_ABS      = ST_DIV_LAST + 1;
    localparam int ST_MUL      = ST_ABS + 1;
    localparam int ST_RED0     = ST_MUL + 1;
    localparam int ST_RED1     = ST_RED0 + 1;
    localparam int ST_RED2     = ST_RED1 + 1;
    localparam int ST_TAY0     = ST_RED2 + 1;
    localparam int ST_TAY_LAST = ST_TAY0 + 2 * TAYLOR_TERMS - 1;
    localparam int ST_SUM      = ST_TAY_LAST + 1;
    localparam int ST_PROD     = ST_SUM + 1;
    localparam int ST_OUT      = ST_PROD + 1;
    localparam int NUM_STAGES  = ST_OUT + 1;

    localparam logic [RES_W-1:0] SAT_VALUE = '1;

    typedef struct packed {
        logic bad;   // at or below absolute zero
        logic neg;   // exponent is negative
        logic ovf;   // exponent magnitude at or above the limit
    } flags_t;

endpackage

/* rtl/core/thermistor_beta_resistance.sv */
// Throughput: one beat per cycle while m_ready does not stall the output; each of the 55
// stages holds one item and moves it on whenever the stage ahead is empty or moving, so
// bubbles close up under an output stall.
// Reset (aresetn low, synchronous): all stage valid bits clear, beta_reg returns to 3455
// and nominal_reg to 10000. Uses tbr_pkg.
module thermistor_beta_resistance (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tbr_pkg::ADDR_W-1:0]    paddr,
    input  logic [tbr_pkg::DATA_W-1:0]    pwdata,
    output logic [tbr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [tbr_pkg::TEMP_W-1:0] s_temperature,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tbr_pkg::RES_W-1:0]     m_resistance,
    output logic                          m_saturated
);
    import tbr_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land on the access phase; reads are
    // combinational from the register selected by paddr[2].
    // ------------------------------------------------------------------
    logic [BETA_W-1:0] beta_reg;
    logic [NOM_W-1:0]  nominal_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg    <= BETA_RESET;
            nominal_reg <= NOMINAL_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                CFG_BETA:    beta_reg    <= pwdata[BETA_W-1:0];
                CFG_NOMINAL: nominal_reg <= pwdata[NOM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_BETA:    prdata = {{(DATA_W-BETA_W){1'b0}}, beta_reg};
            CFG_NOMINAL: prdata = {{(DATA_W-NOM_W){1'b0}}, nominal_reg};
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage control. A stage may load when it is empty or when the stage
    // ahead of it loads; the output stage loads when it is empty or its beat is taken.
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[ST_OUT] = ~v_reg[ST_OUT] | m_ready;
        for (int i = ST_OUT - 1; i >= 0; i--) begin
            en[i] = ~v_reg[i] | en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) begin
                v_reg[0] <= s_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign s_ready = en[0];
    assign m_valid = v_reg[ST_OUT];

    // ------------------------------------------------------------------
    // Status flags travel with each item. The sign of the exponent is set
    // at the absolute-value stage and the overflow at the first reduction
    // stage; every other stage copies them.
    // ------------------------------------------------------------------
    flags_t flags_reg [ST_IN:ST_PROD];
    flags_t flags_next [ST_DIV0:ST_PROD];

    // Input stage: absolute temperature, and a divisor that is safe even
    // for temperatures at or below absolute zero.
    logic [17:0]         th_next;
    logic                bad_next;
    logic [15:0]         dvs_reg [ST_IN:ST_DIV_LAST-1];

    assign th_next  = {{2{s_temperature[TEMP_W-1]}}, s_temperature} + KELVIN_OFFSET;
    assign bad_next = th_next[17] || (th_next == 18'd0);

    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            dvs_reg[ST_IN] <= bad_next ? 16'd1 : th_next[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider: four quotient bits per stage over ten stages.
    // The dividend is a constant, so its bits are fed in as literals.
    // ------------------------------------------------------------------
    logic [15:0]      drem_reg [ST_DIV0:ST_DIV_LAST-1];
    logic [NUM_W-1:0] dq_reg   [ST_DIV0:ST_DIV_LAST];

    for (genvar gd = 0; gd < DIV_STAGES; gd++) begin : g_div
        localparam int IDX = ST_DIV0 + gd;
        logic [15:0]      rem_in;
        logic [NUM_W-1:0] q_in;
        logic [15:0]      rem_next;
        logic [NUM_W-1:0] q_next;
        logic [16:0]      trial;

        if (gd == 0) begin : g_first
            assign rem_in = '0;
            assign q_in   = '0;
        end else begin : g_rest
            assign rem_in = drem_reg[IDX-1];
            assign q_in   = dq_reg[IDX-1];
        end

        always_comb begin
            rem_next = rem_in;
            q_next   = q_in;
            trial    = '0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                trial = {rem_next, RECIP_NUM[NUM_W-1-DIV_STEPS*gd-j]};
                if (trial >= {1'b0, dvs_reg[IDX-1]}) begin
                    rem_next = 16'(trial - {1'b0, dvs_reg[IDX-1]});
                    q_next   = {q_next[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = trial[15:0];
                    q_next   = {q_next[NUM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[IDX]) begin
                dq_reg[IDX] <= q_next;
            end
        end

        if (gd < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en[IDX]) begin
                    drem_reg[IDX] <= rem_next;
                    dvs_reg[IDX]  <= dvs_reg[IDX-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Reciprocal difference and its magnitude.
    // ------------------------------------------------------------------
    logic [NUM_W:0]   r_next;
    logic [NUM_W-1:0] ar_reg;

    assign r_next = {1'b0, dq_reg[ST_DIV_LAST]} - {1'b0, RECIP_T0};

    always_ff @(posedge aclk) begin
        if (en[ST_ABS]) begin
            ar_reg <= r_next[NUM_W] ? (~r_next[NUM_W-1:0] + 1'b1) : r_next[NUM_W-1:0];
        end
    end

    // Exponent magnitude: |r| times B.
    logic [AXP_W-1:0] axp_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_MUL]) begin
            axp_reg <= ar_reg * beta_reg;
        end
    end

    // ------------------------------------------------------------------
    // Range reduction. The offset of 47 ln2 keeps the reduced value
    // positive; k + 47 comes out of a seven-bit division by the constant
    // ln2, split over two stages.
    // ------------------------------------------------------------------
    logic             ovf_next;
    logic [RED_W-1:0] shifted_reg;
    logic [RED_W-1:0] rr_reg;
    logic [3:0]       kh_reg;
    logic [RED_W-1:0] red1_rem;
    logic [3:0]       red1_k;
    logic [RED_W-1:0] red2_rem;
    logic [2:0]       red2_k;
    logic [K_W-1:0]   koff_reg [ST_RED2:ST_PROD];
    logic [31:0]      f_reg    [ST_RED2:ST_TAY_LAST-2];

    assign ovf_next = |axp_reg[AXP_W-1:LIMIT_LOG2];

    always_ff @(posedge aclk) begin
        if (en[ST_RED0]) begin
            if (flags_reg[ST_MUL].neg) begin
                shifted_reg <= RANGE_OFFSET - RED_W'(axp_reg[LIMIT_LOG2-1:0]);
            end else begin
                shifted_reg <= RANGE_OFFSET + RED_W'(axp_reg[LIMIT_LOG2-1:0]);
            end
        end
    end

    always_comb begin
        red1_rem = shifted_reg;
        red1_k   = '0;
        for (int j = 6; j >= 3; j--) begin
            if (red1_rem >= (RED_W'(LN2_F) << j)) begin
                red1_rem = red1_rem - (RED_W'(LN2_F) << j);
                red1_k   = {red1_k[2:0], 1'b1};
            end else begin
                red1_k   = {red1_k[2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_RED1]) begin
            rr_reg <= red1_rem;
            kh_reg <= red1_k;
        end
    end

    always_comb begin
        red2_rem = rr_reg;
        red2_k   = '0;
        for (int j = 2; j >= 0; j--) begin
            if (red2_rem >= (RED_W'(LN2_F) << j)) begin
                red2_rem = red2_rem - (RED_W'(LN2_F) << j);
                red2_k   = {red2_k[1:0], 1'b1};
            end else begin
                red2_k   = {red2_k[1:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_RED2]) begin
            f_reg[ST_RED2]    <= red2_rem[31:0];
            koff_reg[ST_RED2] <= {kh_reg, red2_k};
        end
        for (int i = ST_RED2 + 1; i <= ST_TAY_LAST - 2; i++) begin
            if (en[i]) begin
                f_reg[i] <= f_reg[i-1];
            end
        end
        for (int i = ST_RED2 + 1; i <= ST_PROD; i++) begin
            if (en[i]) begin
                koff_reg[i] <= koff_reg[i-1];
            end
        end
    end

    // Flag pipeline.
    always_comb begin
        for (int i = ST_DIV0; i <= ST_PROD; i++) begin
            flags_next[i] = flags_reg[i-1];
        end
        flags_next[ST_ABS].neg  = r_next[NUM_W];
        flags_next[ST_RED0].ovf = ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            flags_reg[ST_IN] <= '{bad: bad_next, neg: 1'b0, ovf: 1'b0};
        end
        for (int i = ST_DIV0; i <= ST_PROD; i++) begin
            if (en[i]) begin
                flags_reg[i] <= flags_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Taylor series of exp(f), two stages per term. The first multiplies
    // the previous term by f; the second divides by n exactly through a
    // multiply by ceil(2^37 / n), valid for 32-bit dividends. The running
    // sum picks up each term one stage later.
    // ------------------------------------------------------------------
    logic [63:0]           p_reg   [1:TAYLOR_TERMS];
    logic [68:0]           d_reg   [1:TAYLOR_TERMS];
    logic [SUM_W-1:0]      sum_reg [ST_TAY0:ST_TAY_LAST];

    for (genvar gn = 1; gn <= TAYLOR_TERMS; gn++) begin : g_term
        localparam int IDX_A = ST_TAY0 + 2 * (gn - 1);
        localparam int IDX_B = IDX_A + 1;
        localparam logic [MULT_W-1:0] RECIP_M =
            MULT_W'(((64'd1 << RECIP_SHIFT) + 64'(gn) - 64'd1) / 64'(gn));
        logic [TERM_W-1:0] term_in;
        logic [SUM_W-1:0]  sum_in;

        if (gn == 1) begin : g_first
            assign term_in = ONE_Q;
            assign sum_in  = SUM_W'(ONE_Q);
        end else begin : g_rest
            assign term_in = TERM_W'(d_reg[gn-1][68:RECIP_SHIFT]);
            assign sum_in  = sum_reg[IDX_A-1] + SUM_W'(d_reg[gn-1][68:RECIP_SHIFT]);
        end

        always_ff @(posedge aclk) begin
            if (en[IDX_A]) begin
                p_reg[gn]      <= 64'(term_in) * 64'(f_reg[IDX_A-1]);
                sum_reg[IDX_A] <= sum_in;
            end
            if (en[IDX_B]) begin
                d_reg[gn]      <= 69'(p_reg[gn][63:32]) * 69'(RECIP_M);
                sum_reg[IDX_B] <= sum_reg[IDX_A];
            end
        end
    end

    // ------------------------------------------------------------------
    // Scale: R25 times exp(f), then by 2^k and 2^-32 in one right shift of
    // a pre-shifted product, with saturation at the 32-bit range.
    // ------------------------------------------------------------------
    logic [SUM_W-1:0]            sumf_reg;
    logic [PROD_W-1:0]           prod_reg;
    logic [K_W-1:0]              sh_amt;
    logic [PROD_W+PRE_SHIFT-1:0] scaled;
    logic                        range_sat;
    logic [RES_W-1:0]            res_next;
    logic                        sat_next;

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            sumf_reg <= sum_reg[ST_TAY_LAST] + SUM_W'(d_reg[TAYLOR_TERMS][68:RECIP_SHIFT]);
        end
        if (en[ST_PROD]) begin
            prod_reg <= nominal_reg * sumf_reg;
        end
    end

    assign sh_amt    = SHIFT_BIAS - koff_reg[ST_PROD];
    assign scaled    = {prod_reg, {PRE_SHIFT{1'b0}}} >> sh_amt;
    assign range_sat = |scaled[PROD_W+PRE_SHIFT-1:RES_W];

    // Special cases override the computed value: absolute zero saturates, and an out-of-range
    // exponent gives zero if negative or with a zero nominal, and saturation otherwise.
    always_comb begin
        if (flags_reg[ST_PROD].bad) begin
            res_next = SAT_VALUE;
            sat_next = 1'b1;
        end else if (flags_reg[ST_PROD].ovf) begin
            if (flags_reg[ST_PROD].neg || (nominal_reg == '0)) begin
                res_next = '0;
                sat_next = 1'b0;
            end else begin
                res_next = SAT_VALUE;
                sat_next = 1'b1;
            end
        end else if (range_sat) begin
            res_next = SAT_VALUE;
            sat_next = 1'b1;
        end else begin
            res_next = scaled[RES_W-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            m_resistance <= res_next;
            m_saturated  <= sat_next;
        end
    end

endmodule

/* rtl/core/tbr_checker.sv */
// Port-level checker for thermistor_beta_resistance, attached by the bind below.
// Depends on tbr_pkg and the top level's port names.
module tbr_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [tbr_pkg::RES_W-1:0] m_resistance,
    input logic                      m_saturated
);
    import tbr_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_resistance) && $stable(m_saturated))
        else $error("result beat changed while stalled");

    // A saturated beat always carries the full-scale value.
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_resistance == SAT_VALUE)
        else $error("saturated flag without full-scale resistance");

    // With the output stage empty, the whole pipeline can advance.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with an empty output stage");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat valid after reset");

endmodule

bind thermistor_beta_resistance tbr_checker u_tbr_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_resistance (m_resistance),
    .m_saturated  (m_saturated)
);

/* tb/tb_thermistor_beta_resistance.sv */
// Self-checking bench for thermistor_beta_resistance: drives temperature beats and APB writes,
// predicts each resistance with an independent fixed-point B-equation and compares in order.
// Depends on the RTL top level and tbr_pkg.
module tb_thermistor_beta_resistance;
    import tbr_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int LATENCY      = 54;

    typedef struct {
        logic [RES_W-1:0] ohms;
        logic             sat;
    } ohms_t;

    // Holds the predicted resistances in acceptance order and checks the result beats.
    class resistance_book;
        logic [BETA_W-1:0] beta;
        logic [NOM_W-1:0]  nominal;
        ohms_t             pending_ohms[$];
        int                errors;

        function new();
            beta    = BETA_RESET;
            nominal = NOMINAL_RESET;
            errors  = 0;
        endfunction

        // B-parameter equation in Q32 fixed point with exact wide products.
        function ohms_t beta_equation(logic signed [TEMP_W-1:0] temp);
            ohms_t        o;
            int           th;
            logic [63:0]  num, ar, ax, lim, ln2f, shifted, k_off, f, term, sum;
            longint       r, x, k, s;
            logic [127:0] p, v;
            bit           neg;
            num  = 64'd100 << FRAC_BITS;
            lim  = 64'd32 << FRAC_BITS;
            ln2f = 64'h2C5C85FDF473DE6B >> (62 - FRAC_BITS);
            th   = int'(temp) + 27315;
            // At or below absolute zero the resistance is unbounded.
            if (th <= 0) begin
                o.ohms = '1;
                o.sat  = 1'b1;
                return o;
            end
            r   = longint'(num / 64'(th)) - longint'(num / 64'd29815);
            neg = r < 0;
            ar  = neg ? 64'(-r) : 64'(r);
            if (beta == 0) begin
                ax = 0;
            end else if (ar > lim / 64'(beta)) begin
                ax = lim;
            end else begin
                ax = ar * 64'(beta);
            end
            // Exponent at or beyond +/-32: hard saturation, or zero when negative or with a zero nominal.
            if (ax >= lim) begin
                o.ohms = (neg || nominal == 0) ? '0 : '1;
                o.sat  = !(neg || nominal == 0);
                return o;
            end
            x       = neg ? -longint'(ax) : longint'(ax);
            shifted = 64'(x + longint'(64'd47 * ln2f));
            k_off   = shifted / ln2f;
            f       = shifted - k_off * ln2f;
            k       = longint'(k_off) - 47;
            term    = 64'd1 << FRAC_BITS;
            sum     = term;
            for (int n = 1; n <= 18; n++) begin
                p    = 128'(term) * 128'(f);
                term = p[FRAC_BITS +: 64] / 64'(n);
                sum += term;
            end
            p = 128'(nominal) * 128'(sum);
            s = FRAC_BITS - k;
            v = (s >= 0) ? (p >> s) : (p << (-s));
            if (v > 128'hFFFF_FFFF) begin
                o.ohms = '1;
                o.sat  = 1'b1;
            end else begin
                o.ohms = v[31:0];
                o.sat  = 1'b0;
            end
            return o;
        endfunction

        function void note_temperature(logic signed [TEMP_W-1:0] temp);
            pending_ohms.push_back(beta_equation(temp));
        endfunction

        function void check_resistance(logic [RES_W-1:0] ohms, logic sat);
            ohms_t e;
            if (pending_ohms.size() == 0) begin
                $error("unexpected result beat: resistance %0d saturated %0b", ohms, sat);
                errors++;
                return;
            end
            e = pending_ohms.pop_front();
            if (ohms !== e.ohms) begin
                $error("resistance: expected %0d, got %0d", e.ohms, ohms);
                errors++;
            end
            if (sat !== e.sat) begin
                $error("saturated: expected %0b, got %0b", e.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic                     aclk;
    logic                     aresetn;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_W-1:0]        paddr;
    logic [DATA_W-1:0]        pwdata;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [TEMP_W-1:0] s_temperature;
    logic                     m_valid;
    logic                     m_ready;
    logic [RES_W-1:0]         m_resistance;
    logic                     m_saturated;

    resistance_book book = new();
    bit             no_idle = 1'b0;   // when set, neither side inserts gaps
    int             results_seen = 0;
    int             cycle_count = 0;

    thermistor_beta_resistance dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_temperature(s_temperature),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_resistance(m_resistance), .m_saturated(m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung pipeline or a lost beat ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb_thermistor_beta_resistance: errors");
            $finish;
        end
    end

    // Both channels are sampled at the falling edge, away from any input change,
    // so the beat that the next rising edge accepts is seen exactly.
    always @(negedge aclk) begin
        if (aresetn && s_valid && s_ready) book.note_temperature(s_temperature);
        if (aresetn && m_valid && m_ready) begin
            book.check_resistance(m_resistance, m_saturated);
            results_seen++;
        end
    end

    // One APB write: setup cycle, then access cycle; the register takes the
    // value at the edge that ends the access cycle. The predictor follows.
    task automatic apb_write(logic reg_sel, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({reg_sel, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == CFG_BETA) book.beta = value[BETA_W-1:0];
        else book.nominal = value[NOM_W-1:0];
    endtask

    // Offers one temperature beat after a random gap and returns at the edge that accepts it.
    // A zero gap keeps valid high so back-to-back beats get a single assignment per edge.
    task automatic send_temperature(logic signed [TEMP_W-1:0] temp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_temperature <= temp;
        forever begin
            @(negedge aclk);
            if (s_ready) break;
        end
        @(posedge aclk);
    endtask

    // Mostly plausible sensor temperatures, with some raw 16-bit patterns that
    // reach below absolute zero and far above the rated range.
    function automatic logic signed [TEMP_W-1:0] random_temperature();
        if ($urandom_range(0, 9) < 8) return TEMP_W'(int'($urandom_range(0, 35500)) - 5500);
        return TEMP_W'($urandom);
    endfunction

    // Waits until every predicted result has come back, then lets the pipe drain.
    task automatic drain();
        s_valid <= 1'b0;
        while (book.pending_ohms.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Receiver: random stalls per beat; once, after 200 results, it holds off
    // long enough for the whole pipeline to fill and push back on the input.
    initial begin : receiver
        int  gap;
        bit  held;
        held    = 1'b0;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 10);
            if (!held && results_seen >= 200) begin
                held = 1'b1;
                gap  = 300;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            forever begin
                @(negedge aclk);
                if (m_valid) break;
            end
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        logic signed [TEMP_W-1:0] corner[$];
        logic [BETA_W-1:0]        betas[6];
        logic [NOM_W-1:0]         noms[6];
        corner = '{-16'sd5500, 16'sd30000, 16'sd0, 16'sd2500, -16'sd27315, -16'sd27316,
                   -16'sd27314, -16'sd32768, 16'sd32767, 16'sh5555, 16'shAAAA, -16'sd1,
                   16'sd1, 16'sd2499, 16'sd2501, -16'sd27000, 16'sd10000, -16'sd4000};
        // Includes zero beta, zero nominal, both register maxima and typical parts.
        betas = '{16'd3455, 16'd0, 16'hFFFF, 16'd1, 16'd3950, 16'd0};
        noms  = '{24'd10000, 24'd4700, 24'hFFFFFF, 24'd0, 24'd100000, 24'd0};
        betas[5] = 16'($urandom);
        noms[5]  = 24'($urandom);

        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_temperature = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // First phase runs on reset values, so the corner list checks them.
        foreach (corner[i]) send_temperature(corner[i]);
        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                drain();
                apb_write(CFG_BETA, DATA_W'(betas[ph]));
                apb_write(CFG_NOMINAL, DATA_W'(noms[ph]));
                foreach (corner[i]) if (i % 3 == 0) send_temperature(corner[i]);
            end
            no_idle = (ph == 2);
            repeat (180) send_temperature(random_temperature());
        end
        drain();
        if (book.errors == 0 && book.pending_ohms.size() == 0) begin
            $display("tb_thermistor_beta_resistance: clean");
        end else begin
            $display("tb_thermistor_beta_resistance: errors");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/core/tbr_pkg.sv
rtl/core/thermistor_beta_resistance.sv
rtl/core/tbr_checker.sv
tb/tb_thermistor_beta_resistance.sv
